### rtl/sdp_pkg.sv
// shared types and constants for the spectral dealias projection pipeline
package sdp_pkg;

    // grid limits and register reset
    localparam int         MAX_GRID   = 256;
    localparam logic [8:0] GRID_RESET = 9'd32;
    localparam logic [7:0] CUT_RESET  = 8'd10;

    // reciprocal of three in 12 fraction bits, exact for grid sizes below 512
    localparam logic [10:0] RECIP3     = 11'd1366;
    localparam int          RECIP3_SHR = 12;

    // datapath widths
    localparam int CW  = 32;            // coefficient width
    localparam int KW  = 10;            // signed wavenumber width
    localparam int PW  = KW + CW;       // wavenumber times coefficient
    localparam int DW  = PW + 1;        // dot product
    localparam int NW  = KW + DW;       // wavenumber times dot product
    localparam int QW  = 32;            // quotient magnitude
    localparam int DVW = 16;            // divisor width, |k|^2 of a kept mode
    localparam int MW  = QW + DVW;      // dividend magnitude
    localparam int LANES = 4;

    // coefficients and flags that ride along with a beat
    typedef struct packed {
        logic signed [CW-1:0] ur;
        logic signed [CW-1:0] ui;
        logic signed [CW-1:0] vr;
        logic signed [CW-1:0] vi;
        logic                 removed;
        logic                 mean;
    } t_side;

endpackage

### rtl/sdp_decode.sv
// index to wavenumber mapping, grid and two-thirds cutoff test
module sdp_decode import sdp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [7:0]           i_row_index,
    input  logic [7:0]           i_col_index,
    input  logic signed [CW-1:0] i_u_re,
    input  logic signed [CW-1:0] i_u_im,
    input  logic signed [CW-1:0] i_v_re,
    input  logic signed [CW-1:0] i_v_im,
    input  logic [8:0]           i_n,
    input  logic [7:0]           i_cut,
    output logic                 o_valid,
    output logic signed [KW-1:0] o_kx,
    output logic signed [KW-1:0] o_ky,
    output t_side                o_side
);

    logic                 r_valid;
    logic signed [KW-1:0] r_kx, r_ky;
    t_side                r_side;
    logic signed [KW-1:0] n_kx, n_ky;
    logic [KW-1:0]        ax, ay;
    logic                 in_grid, removed;

    // wrap indices above half the grid to negative wavenumbers
    always_comb begin
        n_kx = ({1'b0, i_row_index} <= {1'b0, i_n[8:1]})
             ? $signed({2'b00, i_row_index})
             : $signed({2'b00, i_row_index} - {1'b0, i_n});
        n_ky = ({1'b0, i_col_index} <= {1'b0, i_n[8:1]})
             ? $signed({2'b00, i_col_index})
             : $signed({2'b00, i_col_index} - {1'b0, i_n});
        ax = n_kx[KW-1] ? KW'(-n_kx) : KW'(n_kx);
        ay = n_ky[KW-1] ? KW'(-n_ky) : KW'(n_ky);
        in_grid = ({1'b0, i_row_index} < i_n) && ({1'b0, i_col_index} < i_n);
        removed = !in_grid || (ax > {2'b00, i_cut}) || (ay > {2'b00, i_cut});
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_kx           <= n_kx;
            r_ky           <= n_ky;
            r_side.ur      <= i_u_re;
            r_side.ui      <= i_u_im;
            r_side.vr      <= i_v_re;
            r_side.vi      <= i_v_im;
            r_side.removed <= removed;
            r_side.mean    <= !removed && (n_kx == '0) && (n_ky == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_kx    = r_kx;
    assign o_ky    = r_ky;
    assign o_side  = r_side;

endmodule

### rtl/sdp_dot.sv
// four stages: products, dot products, k times dot, sign and magnitude split
module sdp_dot import sdp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [KW-1:0] i_kx,
    input  logic signed [KW-1:0] i_ky,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [MW-1:0]        o_num [LANES],
    output logic [LANES-1:0]     o_neg,
    output logic [DVW-1:0]       o_k2,
    output t_side                o_side
);

    logic [3:0]           r_v;
    t_side                r_side [4];
    logic signed [KW-1:0] r_kx [3];
    logic signed [KW-1:0] r_ky [3];
    logic [DVW-1:0]       r_k2 [4];
    logic signed [PW-1:0] r_pxu, r_pyv, r_pxi, r_pyi;
    logic signed [DW-1:0] r_dre, r_dim;
    logic signed [NW-1:0] r_a [LANES];
    logic [MW-1:0]        r_num [LANES];
    logic [LANES-1:0]     r_neg;
    logic signed [2*KW-1:0] k2_full;
    logic signed [NW-1:0]   mag [LANES];

    assign k2_full = i_kx * i_kx + i_ky * i_ky;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            mag[l] = r_a[l][NW-1] ? -r_a[l] : r_a[l];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxu     <= i_kx * i_side.ur;
            r_pyv     <= i_ky * i_side.vr;
            r_pxi     <= i_kx * i_side.ui;
            r_pyi     <= i_ky * i_side.vi;
            r_k2[0]   <= k2_full[DVW-1:0];
            r_kx[0]   <= i_kx;
            r_ky[0]   <= i_ky;
            r_side[0] <= i_side;

            r_dre     <= DW'(r_pxu) + DW'(r_pyv);
            r_dim     <= DW'(r_pxi) + DW'(r_pyi);
            r_k2[1]   <= r_k2[0];
            r_kx[1]   <= r_kx[0];
            r_ky[1]   <= r_ky[0];
            r_side[1] <= r_side[0];

            r_a[0]    <= r_kx[1] * r_dre;
            r_a[1]    <= r_kx[1] * r_dim;
            r_a[2]    <= r_ky[1] * r_dre;
            r_a[3]    <= r_ky[1] * r_dim;
            r_k2[2]   <= r_k2[1];
            r_kx[2]   <= r_kx[1];
            r_ky[2]   <= r_ky[1];
            r_side[2] <= r_side[1];

            for (int l = 0; l < LANES; l++) begin
                r_num[l] <= mag[l][MW-1:0];
                r_neg[l] <= r_a[l][NW-1];
            end
            r_k2[3]   <= r_k2[2];
            r_side[3] <= r_side[2];
        end
    end

    assign o_valid = r_v[3];
    assign o_num   = r_num;
    assign o_neg   = r_neg;
    assign o_k2    = r_k2[3];
    assign o_side  = r_side[3];

endmodule

### rtl/sdp_divider.sv
// restoring divider, one quotient bit per stage, four lanes sharing one divisor
module sdp_divider import sdp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [MW-1:0]    i_num [LANES],
    input  logic [LANES-1:0] i_neg,
    input  logic [DVW-1:0]   i_k2,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo [LANES],
    output logic [LANES-1:0] o_neg,
    output t_side            o_side
);

    logic [QW-1:0]    r_v;
    logic [DVW-1:0]   r_rem  [QW][LANES];
    logic [QW-1:0]    r_lo   [QW][LANES];
    logic [DVW-1:0]   r_d    [QW];
    logic [LANES-1:0] r_neg  [QW];
    t_side            r_side [QW];
    logic [DVW-1:0]   a_rem  [QW][LANES];
    logic [QW-1:0]    a_lo   [QW][LANES];
    logic [DVW-1:0]   a_d    [QW];
    logic [DVW-1:0]   n_rem  [QW][LANES];
    logic [QW-1:0]    n_lo   [QW][LANES];
    logic [DVW:0]     trial  [QW][LANES];
    logic             fits   [QW][LANES];

    // one shift and conditional subtract per stage
    always_comb begin
        for (int s = 0; s < QW; s++) begin
            a_d[s] = (s == 0) ? i_k2 : r_d[(s == 0) ? 0 : s-1];
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    a_rem[s][l] = i_num[l][MW-1:QW];
                    a_lo[s][l]  = i_num[l][QW-1:0];
                end else begin
                    a_rem[s][l] = r_rem[s-1][l];
                    a_lo[s][l]  = r_lo[s-1][l];
                end
                trial[s][l] = {a_rem[s][l], a_lo[s][l][QW-1]};
                fits[s][l]  = trial[s][l] >= {1'b0, a_d[s]};
                n_rem[s][l] = fits[s][l] ? DVW'(trial[s][l] - {1'b0, a_d[s]})
                                         : trial[s][l][DVW-1:0];
                n_lo[s][l]  = {a_lo[s][l][QW-2:0], fits[s][l]};
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_d[s]    <= a_d[s];
                r_neg[s]  <= (s == 0) ? i_neg  : r_neg[(s == 0) ? 0 : s-1];
                r_side[s] <= (s == 0) ? i_side : r_side[(s == 0) ? 0 : s-1];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_lo[s][l]  <= n_lo[s][l];
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_neg   = r_neg[QW-1];
    assign o_side  = r_side[QW-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_lo[QW-1][l];
        end
    end

endmodule

### rtl/spectral_dealias_projection.sv
// top level: config register, pipeline wiring, final subtract and saturation
//
// Usage:
//   input channel: i_in_valid / o_in_ready carry one Fourier mode per beat
//     (row and column index, complex u and v coefficients, Q8.24).
//   output channel: o_out_valid / i_out_ready carry one projected mode per
//     beat with the mode_removed and saturated flags, in input order.
//   config channel: i_cfg_valid / o_cfg_ready write grid_size; write only
//     while no beat is in flight. o_cfg_ready is always high.
// Pipeline: from input beat to output beat a mode passes one decode stage,
//   four product stages, 32 divider stages (one quotient bit each) and the
//   output register.
// Throughput: one beat per cycle while the receiver takes beats; every
//   stage is a register and the 32-stage divider bounds the depth.
// Stall: when the output beat is not taken the whole pipeline holds and
//   o_in_ready goes low; nothing is dropped or repeated.
// Reset: synchronous active low; empties the pipeline and sets grid_size
//   to 32.
module spectral_dealias_projection import sdp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [8:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_row_index,
    input  logic [7:0]           i_col_index,
    input  logic signed [CW-1:0] i_u_re,
    input  logic signed [CW-1:0] i_u_im,
    input  logic signed [CW-1:0] i_v_re,
    input  logic signed [CW-1:0] i_v_im,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [CW-1:0] o_u_re_out,
    output logic signed [CW-1:0] o_u_im_out,
    output logic signed [CW-1:0] o_v_re_out,
    output logic signed [CW-1:0] o_v_im_out,
    output logic                 o_mode_removed,
    output logic                 o_saturated
);

    logic [8:0]           r_n;
    logic [7:0]           r_cut;
    logic [8:0]           n_clamped;
    logic [19:0]          cut_prod;
    logic                 en;
    logic                 dec_valid, dot_valid, div_valid;
    logic signed [KW-1:0] dec_kx, dec_ky;
    t_side                dec_side, dot_side, div_side;
    logic [MW-1:0]        dot_num [LANES];
    logic [LANES-1:0]     dot_neg, div_neg;
    logic [DVW-1:0]       dot_k2;
    logic [QW-1:0]        div_quo [LANES];
    logic signed [CW-1:0] base [LANES];
    logic signed [CW-1:0] n_res [LANES];
    logic [LANES-1:0]     clip;
    logic signed [QW+1:0] qs [LANES];
    logic signed [CW+2:0] diff [LANES];
    logic                 r_out_valid;
    logic signed [CW-1:0] r_res [LANES];
    logic                 r_removed, r_sat;

    // grid size and cutoff derived from the written value
    assign n_clamped = (i_cfg_data > 9'(MAX_GRID)) ? 9'(MAX_GRID) : i_cfg_data;
    assign cut_prod  = {n_clamped[8:1], 1'b0} * RECIP3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= GRID_RESET;
            r_cut <= CUT_RESET;
        end else if (i_cfg_valid) begin
            r_n   <= {n_clamped[8:1], 1'b0};
            r_cut <= cut_prod[RECIP3_SHR+7:RECIP3_SHR];
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline advances whenever the output register is free or drains
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    sdp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in_valid),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_u_re      (i_u_re),
        .i_u_im      (i_u_im),
        .i_v_re      (i_v_re),
        .i_v_im      (i_v_im),
        .i_n         (r_n),
        .i_cut       (r_cut),
        .o_valid     (dec_valid),
        .o_kx        (dec_kx),
        .o_ky        (dec_ky),
        .o_side      (dec_side)
    );

    sdp_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dec_valid),
        .i_kx    (dec_kx),
        .i_ky    (dec_ky),
        .i_side  (dec_side),
        .o_valid (dot_valid),
        .o_num   (dot_num),
        .o_neg   (dot_neg),
        .o_k2    (dot_k2),
        .o_side  (dot_side)
    );

    sdp_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dot_valid),
        .i_num   (dot_num),
        .i_neg   (dot_neg),
        .i_k2    (dot_k2),
        .i_side  (dot_side),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_neg   (div_neg),
        .o_side  (div_side)
    );

    // signed quotient, subtract from the input component, saturate
    assign base[0] = div_side.ur;
    assign base[1] = div_side.ui;
    assign base[2] = div_side.vr;
    assign base[3] = div_side.vi;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            qs[l]   = div_neg[l] ? -$signed({2'b00, div_quo[l]})
                                 :  $signed({2'b00, div_quo[l]});
            diff[l] = (CW+3)'(base[l]) - (CW+3)'(qs[l]);
            if (diff[l] > (CW+3)'(33'sh0_7FFF_FFFF)) begin
                n_res[l] = 32'sh7FFF_FFFF;
                clip[l]  = 1'b1;
            end else if (diff[l] < -(CW+3)'(33'sh0_8000_0000)) begin
                n_res[l] = -32'sh8000_0000;
                clip[l]  = 1'b1;
            end else begin
                n_res[l] = diff[l][CW-1:0];
                clip[l]  = 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                if (div_side.removed) begin
                    r_res[l] <= '0;
                end else if (div_side.mean) begin
                    r_res[l] <= base[l];
                end else begin
                    r_res[l] <= n_res[l];
                end
            end
            r_removed <= div_side.removed;
            r_sat     <= !div_side.removed && !div_side.mean && (clip != '0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_u_re_out     = r_res[0];
    assign o_u_im_out     = r_res[1];
    assign o_v_re_out     = r_res[2];
    assign o_v_im_out     = r_res[3];
    assign o_mode_removed = r_removed;
    assign o_saturated    = r_sat;

`ifndef ASSERT_OFF
    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode_removed |-> !o_saturated && o_u_re_out == 0 &&
        o_u_im_out == 0 && o_v_re_out == 0 && o_v_im_out == 0)
        else $error("removed mode not zeroed");
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
